>>> design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on a clk and an arst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge out of reset
`define KSS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("kss assertion failed");

// check on every edge, reset included
`define KSS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("kss assertion failed during or after reset");

`endif

>>> design/kss_pkg.sv
// Package for the shared-store stack block: codes, defaults, command struct.
// No dependencies.
package kss_pkg;

	localparam int NUM_STACKS_DEF = 4;
	localparam int CAPACITY_DEF   = 16;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_POP  = 2'd1;
	localparam logic [1:0] OP_PEEK = 2'd2;
	localparam logic [1:0] OP_SIZE = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic accept;
		logic commit;
	} cmd_t;

endpackage

>>> design/kss_ctrl.sv
// Controller: input handshake, two-state sequencer, output valid.
// Depends on kss_pkg.
module kss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output kss_pkg::cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign in_stall   = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign cmd.accept = in_valid && (state_q == S_IDLE);
	assign cmd.commit = (state_q == S_EXEC) && out_free;
	assign out_valid  = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/kss_dp.sv
// Datapath: slot data and link memories, stack tops, counts, free list, result word.
// Depends on kss_pkg.
module kss_dp #(
	parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEF,
	parameter int CAPACITY   = kss_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kss_pkg::cmd_t      cmd,
	input  logic [1:0]         kind,
	input  logic [1:0]         stack_number,
	input  logic signed [31:0] push_value,
	output logic signed [31:0] data,
	output logic [4:0]         count,
	output logic [1:0]         status
);

	localparam int PW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PW-1:0] LINK_NULL = PW'(CAPACITY);

	logic [31:0]   data_mem [CAPACITY];
	logic [PW-1:0] link_mem [CAPACITY];

	logic [PW-1:0] stack_top_q   [NUM_STACKS];
	logic [PW-1:0] stack_count_q [NUM_STACKS];
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] fill_q;

	logic [1:0]    op_s1;
	logic [SW-1:0] idx_s1;
	logic          ok_s1;
	logic [31:0]   val_s1;
	logic [PW-1:0] addr_s1;
	logic [PW-1:0] top_s1;
	logic          fresh_s1;
	logic          slot_s1;
	logic [PW-1:0] link_rd_s1;
	logic [31:0]   data_rd_s1;

	logic signed [31:0] data_q;
	logic [4:0]         count_q;
	logic [1:0]         status_q;

	logic [SW-1:0] idx;
	logic          sel_ok;
	logic [PW-1:0] top_k;
	logic [PW-1:0] addr;
	logic [PW-1:0] link_eff;
	logic [PW-1:0] cnt_k;
	logic [PW-1:0] cnt_new;
	logic          is_push;
	logic          do_push;
	logic          do_pop;
	logic          link_we;
	logic [PW-1:0] link_wd;
	logic [31:0]   data_n;
	logic [1:0]    status_n;

	assign idx    = SW'(stack_number);
	assign sel_ok = ({30'd0, stack_number} < 32'(NUM_STACKS));
	assign top_k  = stack_top_q[idx];
	assign addr   = (kind == kss_pkg::OP_PUSH) ? free_head_q : top_k;

	assign is_push  = (op_s1 == kss_pkg::OP_PUSH);
	assign do_push  = cmd.commit && ok_s1 && slot_s1 && is_push;
	assign do_pop   = cmd.commit && ok_s1 && slot_s1 && (op_s1 == kss_pkg::OP_POP);
	assign link_eff = fresh_s1 ? (addr_s1 + PW'(1)) : link_rd_s1;
	assign link_we  = do_push || do_pop;
	assign link_wd  = is_push ? top_s1 : free_head_q;
	assign cnt_k    = stack_count_q[idx_s1];

	always_comb begin
		cnt_new  = cnt_k;
		data_n   = 32'd0;
		status_n = kss_pkg::ST_OK;
		if (ok_s1) begin
			unique case (op_s1)
				kss_pkg::OP_PUSH: begin
					if (slot_s1) cnt_new = cnt_k + PW'(1);
					else status_n = kss_pkg::ST_FULL;
				end
				kss_pkg::OP_POP: begin
					if (slot_s1) begin
						data_n = data_rd_s1;
						if (cnt_k != '0) cnt_new = cnt_k - PW'(1);
					end else begin
						status_n = kss_pkg::ST_EMPTY;
					end
				end
				kss_pkg::OP_PEEK: begin
					if (slot_s1) data_n = data_rd_s1;
					else status_n = kss_pkg::ST_EMPTY;
				end
				kss_pkg::OP_SIZE: begin
				end
				default: begin
				end
			endcase
		end
	end

	// capture request and issue memory reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_s1      <= kind;
			idx_s1     <= idx;
			ok_s1      <= sel_ok;
			val_s1     <= push_value;
			addr_s1    <= addr;
			top_s1     <= top_k;
			fresh_s1   <= (addr >= fill_q);
			slot_s1    <= (addr < LINK_NULL);
			link_rd_s1 <= link_mem[addr[AW-1:0]];
			data_rd_s1 <= data_mem[addr[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) link_mem[addr_s1[AW-1:0]] <= link_wd;
		if (do_push) data_mem[addr_s1[AW-1:0]] <= val_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				stack_top_q[i]   <= LINK_NULL;
				stack_count_q[i] <= '0;
			end
			free_head_q <= '0;
			fill_q      <= '0;
		end else begin
			if (do_push) begin
				free_head_q         <= link_eff;
				stack_top_q[idx_s1] <= addr_s1;
				if (fresh_s1) fill_q <= addr_s1 + PW'(1);
			end else if (do_pop) begin
				free_head_q         <= addr_s1;
				stack_top_q[idx_s1] <= link_eff;
			end
			if (do_push || do_pop) stack_count_q[idx_s1] <= cnt_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			data_q   <= data_n;
			count_q  <= ok_s1 ? 5'(cnt_new) : 5'd0;
			status_q <= status_n;
		end
	end

	assign data   = data_q;
	assign count  = count_q;
	assign status = status_q;

endmodule

>>> design/k_stacks_shared_store.sv
// Top level of the shared-store stack block: controller plus datapath.
// Depends on kss_pkg, kss_ctrl, kss_dp.
//
//  channel | handshake            | words
//  --------+----------------------+-------------------------------
//  request | in_valid / in_stall  | kind, stack_number, push_value
//  result  | out_valid / out_stall| data, count, status
//
// The accept reads the slot memories; the commit, in the execute state,
// writes links, tops, counts and the result register. in_stall is high
// in the execute state, which holds while the result register is full
// and stalled. One result per request, always.
// Reset empties every stack; the free list starts implicitly as slots in
// ascending order behind a fill mark, so no clearing pass runs.
module k_stacks_shared_store #(
	parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEF,
	parameter int CAPACITY   = kss_pkg::CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [1:0]         stack_number,
	input  logic signed [31:0] push_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] data,
	output logic [4:0]         count,
	output logic [1:0]         status
);

	kss_pkg::cmd_t cmd;

	kss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	kss_dp #(
		.NUM_STACKS (NUM_STACKS),
		.CAPACITY   (CAPACITY)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.kind         (kind),
		.stack_number (stack_number),
		.push_value   (push_value),
		.data         (data),
		.count        (count),
		.status       (status)
	);

endmodule

>>> design/kss_checker.sv
// Port-level checker for the shared-store stack block, bound to the top level.
// Depends on kss_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kss_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         kind,
	input logic [1:0]         stack_number,
	input logic signed [31:0] push_value,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] data,
	input logic [4:0]         count,
	input logic [1:0]         status
);

	`KSS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
	`KSS_ASSERT(a_one_at_a_time, in_valid && !in_stall |=> in_stall)
	`KSS_ASSERT(a_status_code, out_valid |-> status != 2'd3)
	`KSS_ASSERT(a_empty_zero, out_valid && status == kss_pkg::ST_EMPTY |-> data == 32'sd0 && count == 5'd0)
	`KSS_ASSERT(a_full_zero, out_valid && status == kss_pkg::ST_FULL |-> data == 32'sd0)

endmodule

bind k_stacks_shared_store kss_checker u_kss_checker (.*);
